// File: hw/rtl/kar_pkg.sv
// ----------------------------------------------------------------------------
// kar_pkg
// Shared types and constants of the key auto-repeat picker.
// ----------------------------------------------------------------------------
package kar_pkg;

    // default sizes of the block
    localparam int KEY_COUNT_DEF = 10;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths on the ports
    localparam int KEYS_W   = 10;
    localparam int NOW_W    = 32;
    localparam int ACTION_W = 4;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // packed stream words, padded to whole bytes
    localparam int S_DATA_W = ((KEYS_W + NOW_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ACTION_W + 7) / 8) * 8;

    // register reset values
    localparam logic [CFG_W-1:0] DEFAULT_INITIAL = CFG_W'(21428 / 2);
    localparam logic [CFG_W-1:0] DEFAULT_REPEAT  = CFG_W'(21428 / 20);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_INITIAL = 2'd1,
        PHASE_REPEAT  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] initial_delay;
        logic [CFG_W-1:0] repeat_interval;
    } cfg_t;

endpackage

// File: hw/rtl/key_auto_repeat_picker.sv
// ----------------------------------------------------------------------------
// key_auto_repeat_picker
// Typematic key picker: one key action for each sample of held keys.
// ----------------------------------------------------------------------------
// Each transaction on the s_ channel carries one key sample and the current
// time; each one yields exactly one transaction on the m_ channel with the
// picked action (0 for none, else key index plus one).
// The cfg_ channel writes the initial delay (index 0) and repeat interval
// (index 1); it is always ready and should only be used while the block is
// idle.
// A sample is first captured in the input register; the pick and state
// update then land in the output register, which drives m_tvalid.
// Throughput is one sample per cycle while m_tready is high, set by the combinational pick logic.
// When the receiver stalls, the output register holds its result and the
// input register holds one more sample; s_tready drops once both are full.
// Reset clears the valid flags of both registers, returns the repeat machine
// to idle with a zero time stamp, and loads the default delay and interval.
// ----------------------------------------------------------------------------
module key_auto_repeat_picker
    import kar_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // keys_down[9:0], now_time[41:10]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // action[3:0]

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t                cfg;
    logic                in_valid_reg, in_valid_next;
    logic [KEYS_W-1:0]   in_keys_reg;
    logic [NOW_W-1:0]    in_now_reg;
    logic                out_valid_reg, out_valid_next;
    logic [ACTION_W-1:0] out_action_reg;
    logic [ACTION_W-1:0] action;
    logic                advance;
    logic                s_take;

    kar_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kar_repeat_core #(
        .KEY_COUNT (KEY_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .keys_down (in_keys_reg),
        .now_time  (in_now_reg),
        .cfg       (cfg),
        .action    (action)
    );

    // sample moves into the output register when that one is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_action_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_keys_reg <= s_tdata[KEYS_W-1:0];
            in_now_reg  <= s_tdata[KEYS_W+NOW_W-1:KEYS_W];
        end
        if (advance) begin
            out_action_reg <= action;
        end
    end

endmodule

// File: hw/rtl/kar_cfg_regs.sv
// ----------------------------------------------------------------------------
// kar_cfg_regs
// Holds the initial delay and repeat interval registers.
// ----------------------------------------------------------------------------
module kar_cfg_regs
    import kar_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_INITIAL_DELAY:   cfg_next.initial_delay   = cfg_data;
                REG_REPEAT_INTERVAL: cfg_next.repeat_interval = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_delay   <= DEFAULT_INITIAL;
            cfg_reg.repeat_interval <= DEFAULT_REPEAT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/kar_repeat_core.sv
// ----------------------------------------------------------------------------
// kar_repeat_core
// Repeat state machine and priority pick for one key sample per step.
// ----------------------------------------------------------------------------
module kar_repeat_core
    import kar_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [KEYS_W-1:0]   keys_down,
    input  logic [NOW_W-1:0]    now_time,
    input  cfg_t                cfg,
    output logic [ACTION_W-1:0] action
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS
                         : ((NOW_W > CFG_W) ? NOW_W : CFG_W);

    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     held_reg, held_next;
    logic [TIME_BITS-1:0] stamp_reg, stamp_next;

    logic [KEY_COUNT-1:0] keys;
    logic [KEY_COUNT-1:0] held_mask;
    logic [KEY_COUNT-1:0] cand;
    logic                 held_down;
    phase_t               phase_eff;
    logic [CMP_W-1:0]     now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [CMP_W-1:0]     need;
    logic                 due;
    logic                 found;
    logic [IDX_W-1:0]     pick;

    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            keys[i]      = (i < KEYS_W) ? keys_down[i % KEYS_W] : 1'b0;
            held_mask[i] = (held_reg == IDX_W'(i));
        end
    end

    assign held_down = |(keys & held_mask);
    assign phase_eff = (phase_reg != PHASE_IDLE && !held_down) ? PHASE_IDLE : phase_reg;

    assign now_ext = CMP_W'(now_time);
    assign now_t   = now_ext[TIME_BITS-1:0];
    assign elapsed = now_t - stamp_reg;
    assign need    = (phase_eff == PHASE_INITIAL) ? CMP_W'(cfg.initial_delay)
                                                  : CMP_W'(cfg.repeat_interval);
    assign due     = CMP_W'(elapsed) >= need;

    // held key not yet due is left out of the pick
    assign cand = (phase_eff != PHASE_IDLE && !due) ? (keys & ~held_mask) : keys;

    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found = 1'b1;
                pick  = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        stamp_next = stamp_reg;
        if (step_en) begin
            if (found) begin
                held_next  = pick;
                stamp_next = now_t;
                if (phase_eff != PHASE_IDLE && pick == held_reg) begin
                    phase_next = PHASE_REPEAT;
                end else begin
                    phase_next = PHASE_INITIAL;
                end
            end else if (phase_eff == PHASE_IDLE || due) begin
                phase_next = PHASE_IDLE;
            end else begin
                phase_next = phase_eff;
            end
        end
    end

    // outputs
    always_comb begin
        action = found ? ACTION_W'(pick + IDX_W'(1)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_IDLE;
            held_reg  <= '0;
            stamp_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule
